FILE: design/xor_rle_pair_count_decoder_assert.svh
// Assertion macros for the XOR keyed run-length decoder.
`ifndef XOR_RLE_PAIR_COUNT_DECODER_ASSERT_SVH
`define XOR_RLE_PAIR_COUNT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define XRPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define XRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/xrpc_pkg.sv
// Shared types and constants of the XOR keyed run-length decoder.
`timescale 1ns / 1ps

package xrpc_pkg;

    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 4;   // holds 1..8
    localparam int DATA_LANES  = 8;
    localparam int MAX_RESULTS = 32;
    localparam int RES_W       = 5;   // indexes 0..31 results of one burst

    // register index, taken from paddr[2]
    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_XOR_KEY         = 1'b0;
    localparam reg_idx_t REG_COMPRESSED_MODE = 1'b1;

    typedef enum logic [1:0] {
        MODE_LIT   = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_AFTER = 2'd2
    } decode_mode_t;

    typedef enum logic {
        EMIT_IDLE = 1'b0,
        EMIT_RUN  = 1'b1
    } emit_state_t;

    // burst request from the decoder to the emitter
    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] count;
    } emit_req_t;

    // output register of the emitter
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] value;
        logic [CNT_W-1:0]  count;
        logic              last;
    } emit_out_t;

endpackage

FILE: design/xrpc_emitter.sv
// Burst emitter: packs n copies of a byte into results with one shared subtractor.
`timescale 1ns / 1ps

module xrpc_emitter
    import xrpc_pkg::*;
#(
    parameter int LANES = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  emit_req_t req,
    output logic      busy,
    input  logic      out_ready,
    output emit_out_t out
);

    localparam int EFF_LANES = (LANES > DATA_LANES) ? DATA_LANES : ((LANES < 1) ? 1 : LANES);
    localparam logic [CNT_W-1:0] CHUNK = CNT_W'(EFF_LANES);

    emit_state_t        state_reg, state_next;
    logic [BYTE_W-1:0]  rem_reg, rem_next;
    logic [RES_W-1:0]   res_reg, res_next;
    logic [BYTE_W-1:0]  value_reg, value_next;
    emit_out_t          out_reg, out_next;

    logic               load;
    logic [CNT_W-1:0]   chunk;
    logic [BYTE_W-1:0]  rem_after;
    logic               final_chunk;

    // shared chunk unit: k = min(rem, lanes), rem - k
    assign load        = (state_reg == EMIT_RUN) && (!out_reg.valid || out_ready);
    assign chunk       = (rem_reg < BYTE_W'(EFF_LANES)) ? rem_reg[CNT_W-1:0] : CHUNK;
    assign rem_after   = rem_reg - BYTE_W'(chunk);
    assign final_chunk = (rem_after == '0) || (res_reg == RES_W'(MAX_RESULTS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EMIT_IDLE:
            begin
                if (req.start && (req.count != '0))
                    state_next = EMIT_RUN;
            end
            EMIT_RUN:
            begin
                if (load && final_chunk)
                    state_next = EMIT_IDLE;
            end
            default: state_next = EMIT_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg == EMIT_RUN);
        out  = out_reg;
    end

    always_comb
    begin
        rem_next   = rem_reg;
        res_next   = res_reg;
        value_next = value_reg;
        if ((state_reg == EMIT_IDLE) && req.start)
        begin
            rem_next   = req.count;
            res_next   = '0;
            value_next = req.value;
        end
        else if (load)
        begin
            rem_next = rem_after;
            res_next = res_reg + RES_W'(1);
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (load)
        begin
            out_next.valid = 1'b1;
            out_next.value = value_reg;
            out_next.count = chunk;
            out_next.last  = final_chunk;
        end
        else if (out_ready)
        begin
            out_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EMIT_IDLE;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        value_reg <= value_next;
    end

endmodule

FILE: design/xor_rle_pair_count_decoder.sv
// Top level of the XOR keyed run-length decoder with packed multi-byte results.
`timescale 1ns / 1ps

// Takes one packed byte per input word, removes the XOR key and, in compressed
// mode, expands runs: a byte equal to the one before it opens a run, the next
// byte is a count of 0..255 further copies, and a repeat of the run byte after
// a count adds one copy and is followed by another count. A differing byte
// flagged tlast after a count is dropped. Decoded bytes leave packed up to
// min(LANES, 8) per output word, data_0 in the lowest byte, with byte_count
// telling how many are valid and tlast marking the last word of one input
// byte's burst (at most 32 words per input byte; longer bursts are cut off).
// The block handles one input byte at a time. A literal byte is accepted, then
// passes once through the emitter. A count byte n is accepted and then leaves
// as min(ceil(n / lanes), 32) output words from the shared chunk subtractor
// in the emitter, one output word per cycle unless stalled; a count of zero or
// a dropped byte is only accepted. Downstream stalls (m_tready low) hold the emitter.
// Any byte flagged tlast returns the decode state to its reset values.
// Registers (APB, 4-byte stride): 0x0 xor_key[7:0], reset 0;
// 0x4 compressed_mode[0], reset 1. Write only while the block is idle.

module xor_rle_pair_count_decoder
    import xrpc_pkg::*;
#(
    parameter int LANES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_byte
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // data_0..data_7 [63:0], byte_count [67:64], zero [71:68]
    output logic        m_tlast,   // end_of_burst
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "xor_rle_pair_count_decoder_assert.svh"

    // configuration
    logic [BYTE_W-1:0]  xor_key_reg;
    logic               comp_mode_reg;
    logic               cfg_write;
    reg_idx_t           cfg_idx;

    // decode state
    decode_mode_t       mode_reg, mode_next;
    logic [BYTE_W-1:0]  prev_byte_reg, prev_byte_next;
    logic               prev_valid_reg, prev_valid_next;

    logic               accept;
    logic [BYTE_W-1:0]  key_byte;
    logic               match_prev;
    emit_req_t          req;
    emit_out_t          eout;
    logic               busy;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_XOR_KEY:         prdata[BYTE_W-1:0] = xor_key_reg;
            REG_COMPRESSED_MODE: prdata[0]          = comp_mode_reg;
            default:             prdata             = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_key_reg   <= '0;
            comp_mode_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            if (cfg_idx == REG_XOR_KEY)
                xor_key_reg <= pwdata[BYTE_W-1:0];
            if (cfg_idx == REG_COMPRESSED_MODE)
                comp_mode_reg <= pwdata[0];
        end
    end

    assign s_tready   = !busy;
    assign accept     = s_tvalid && s_tready;
    assign key_byte   = s_tdata ^ xor_key_reg;
    assign match_prev = (key_byte == prev_byte_reg);

    // next decode state
    always_comb
    begin
        mode_next       = mode_reg;
        prev_byte_next  = prev_byte_reg;
        prev_valid_next = prev_valid_reg;
        if (accept)
        begin
            if (comp_mode_reg)
            begin
                unique case (mode_reg)
                    MODE_COUNT:
                    begin
                        mode_next = MODE_AFTER;
                    end
                    MODE_AFTER:
                    begin
                        if (match_prev)
                            mode_next = MODE_COUNT;
                        else if (!s_tlast)
                        begin
                            mode_next       = MODE_LIT;
                            prev_byte_next  = key_byte;
                            prev_valid_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next       = (prev_valid_reg && match_prev) ? MODE_COUNT
                                                                         : MODE_LIT;
                        prev_byte_next  = key_byte;
                        prev_valid_next = 1'b1;
                    end
                endcase
            end
            // end of data restarts decoding
            if (s_tlast)
            begin
                mode_next       = MODE_LIT;
                prev_byte_next  = '0;
                prev_valid_next = 1'b0;
            end
        end
    end

    // burst request for the emitter
    always_comb
    begin
        req.start = accept;
        req.value = key_byte;
        req.count = BYTE_W'(1);
        if (comp_mode_reg)
        begin
            unique case (mode_reg)
                MODE_COUNT:
                begin
                    req.value = prev_byte_reg;
                    req.count = key_byte;
                end
                MODE_AFTER:
                begin
                    if (!match_prev && s_tlast)
                        req.count = '0;
                end
                default: req.count = BYTE_W'(1);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_LIT;
            prev_byte_reg  <= '0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            prev_byte_reg  <= prev_byte_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    xrpc_emitter #(
        .LANES (LANES)
    ) u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .busy      (busy),
        .out_ready (m_tready),
        .out       (eout)
    );

    // lanes at or beyond byte_count read as zero
    always_comb
    begin
        m_tdata = '0;
        for (int k = 0; k < DATA_LANES; k++)
        begin
            if (CNT_W'(k) < eout.count)
                m_tdata[k*BYTE_W +: BYTE_W] = eout.value;
        end
        m_tdata[DATA_LANES*BYTE_W +: CNT_W] = eout.count;
    end

    assign m_tvalid = eout.valid;
    assign m_tlast  = eout.last;

    `XRPC_ASSERT_NOW(a_count_range, clk, rst_n, m_tvalid,
        (eout.count != '0) && (eout.count <= CNT_W'(DATA_LANES)),
        "byte_count out of range")
    `XRPC_ASSERT_NEXT(a_burst_blocks_input, clk, rst_n, accept && (req.count != '0),
        !s_tready, "input not held off during a burst")
    `XRPC_ASSERT_NEXT(a_last_resets_state, clk, rst_n, accept && s_tlast,
        (mode_reg == MODE_LIT) && !prev_valid_reg && (prev_byte_reg == '0),
        "decode state not reset after last byte")
    `XRPC_ASSERT_NOW(a_partial_burst_busy, clk, rst_n, m_tvalid && !m_tlast,
        !s_tready, "input accepted with burst words still pending")

endmodule
